FILE: rtl/fix_tag_value_extractor_defines.svh
// ----------------------------------------------------------------------------
// FIX tag/value extractor assertion macros
// Shared assertion helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIX_TAG_VALUE_EXTRACTOR_DEFINES_SVH
`define FIX_TAG_VALUE_EXTRACTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fix_tag_value_extractor assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fix_tag_value_extractor assertion failed");

`endif

FILE: rtl/fte_pkg.sv
// ----------------------------------------------------------------------------
// FIX tag/value extractor package
// Constants, scan phase codes and the result record shared by the modules.
// ----------------------------------------------------------------------------
package fte_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int OUT_OFF_W       = 16;
  localparam int OUT_DATA_W      = 80;
  localparam int CFG_ADDR_W      = 3;

  localparam logic [7:0] SOH_BYTE   = 8'h01;
  localparam logic [7:0] EQ_BYTE    = 8'h3D;
  localparam logic [7:0] DIGIT_LOW  = 8'h30;
  localparam logic [7:0] DIGIT_HIGH = 8'h39;

  localparam logic REG_TARGET_TAG = 1'b0;

  typedef enum logic [3:0] {
    PH_TAG   = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0]           value_byte;
    logic                 value_valid;
    logic                 message_done;
    logic                 found;
    logic [OUT_OFF_W-1:0] field_start;
    logic [OUT_OFF_W-1:0] value_start;
    logic [OUT_OFF_W-1:0] value_stop;
    logic [OUT_OFF_W-1:0] field_stop;
    logic                 too_long;
  } result_t;

endpackage

FILE: rtl/fte_cfg_regs.sv
// ----------------------------------------------------------------------------
// FIX tag/value extractor configuration registers
// APB-style register port holding the target tag.
// ----------------------------------------------------------------------------
module fte_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [fte_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready,
  output logic [31:0]                    target_tag
);

  logic [31:0] target_tag_r;
  logic        reg_index;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign reg_index  = cfg_paddr[2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_tag_r <= '0;
    end else if (wr_en && (reg_index == fte_pkg::REG_TARGET_TAG)) begin
      target_tag_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (reg_index == fte_pkg::REG_TARGET_TAG) ? target_tag_r : 32'd0;
  assign target_tag = target_tag_r;

endmodule

FILE: rtl/fte_scanner.sv
// ----------------------------------------------------------------------------
// FIX tag/value extractor field scanner
// Per-byte message state and the combinational decision for one byte.
// ----------------------------------------------------------------------------
module fte_scanner #(
  parameter int OFFSET_BITS = fte_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [31:0]      target_tag,
  output logic             has_result,
  output fte_pkg::result_t result
);

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  fte_pkg::phase_t        phase_r, phase_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic                   digit_r, digit_nxt;
  logic                   bad_r, bad_nxt;
  logic [OFFSET_BITS-1:0] fstart_r, fstart_nxt;
  logic                   match_r, match_nxt;
  logic [OFFSET_BITS-1:0] mo_r   [4];
  logic [OFFSET_BITS-1:0] mo_nxt [4];
  logic                   ovf_r, ovf_nxt;

  logic                   pos_max;
  logic [OFFSET_BITS-1:0] pos_next;
  logic [35:0]            acc_x10;
  logic                   tag_ok;
  logic                   emit;
  logic [OFFSET_BITS-1:0] vstop, fstop;

  assign pos_max  = &pos_r;
  assign pos_next = pos_max ? pos_r : pos_r + 1'b1;
  assign acc_x10  = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {32'd0, data_byte[3:0]};
  assign tag_ok   = digit_r && !bad_r && (acc_r != 32'd0) && (acc_r == target_tag) && !match_r;

  always_comb begin
    pos_nxt    = pos_next;
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    digit_nxt  = digit_r;
    bad_nxt    = bad_r;
    fstart_nxt = fstart_r;
    match_nxt  = match_r;
    mo_nxt     = mo_r;
    ovf_nxt    = ovf_r || pos_max;
    emit       = 1'b0;

    case (phase_r)
      fte_pkg::PH_TAG: begin
        if (data_byte == fte_pkg::SOH_BYTE) begin
          phase_nxt  = fte_pkg::PH_TAG;
          acc_nxt    = '0;
          digit_nxt  = 1'b0;
          bad_nxt    = 1'b0;
          fstart_nxt = pos_next;
        end else if (data_byte == fte_pkg::EQ_BYTE) begin
          if (tag_ok) begin
            match_nxt  = 1'b1;
            mo_nxt[0]  = fstart_r;
            mo_nxt[1]  = pos_next;
            phase_nxt  = fte_pkg::PH_VALUE;
          end else begin
            phase_nxt  = fte_pkg::PH_SKIP;
          end
        end else if (data_byte inside {[fte_pkg::DIGIT_LOW:fte_pkg::DIGIT_HIGH]}) begin
          digit_nxt = 1'b1;
          if (!bad_r) begin
            if (|acc_x10[35:32]) begin
              bad_nxt = 1'b1;
            end else begin
              acc_nxt = acc_x10[31:0];
            end
          end
        end else begin
          bad_nxt = 1'b1;
        end
      end
      fte_pkg::PH_SKIP: begin
        if (data_byte == fte_pkg::SOH_BYTE) begin
          phase_nxt  = fte_pkg::PH_TAG;
          acc_nxt    = '0;
          digit_nxt  = 1'b0;
          bad_nxt    = 1'b0;
          fstart_nxt = pos_next;
        end
      end
      fte_pkg::PH_VALUE: begin
        if (data_byte == fte_pkg::SOH_BYTE) begin
          mo_nxt[2] = pos_r;
          mo_nxt[3] = pos_next;
          phase_nxt = fte_pkg::PH_DONE;
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
      end
    endcase

    vstop = (phase_nxt == fte_pkg::PH_VALUE) ? pos_next : mo_nxt[2];
    fstop = (phase_nxt == fte_pkg::PH_VALUE) ? pos_next : mo_nxt[3];

    has_result          = emit || last_byte;
    result              = '0;
    result.value_byte   = emit ? data_byte : 8'd0;
    result.value_valid  = emit;
    result.message_done = last_byte;
    if (last_byte) begin
      result.too_long = ovf_nxt;
      if (match_nxt) begin
        result.found       = 1'b1;
        result.field_start = fte_pkg::OUT_OFF_W'(mo_nxt[0]);
        result.value_start = fte_pkg::OUT_OFF_W'(mo_nxt[1]);
        result.value_stop  = fte_pkg::OUT_OFF_W'(vstop);
        result.field_stop  = fte_pkg::OUT_OFF_W'(fstop);
      end
      pos_nxt    = '0;
      phase_nxt  = fte_pkg::PH_TAG;
      acc_nxt    = '0;
      digit_nxt  = 1'b0;
      bad_nxt    = 1'b0;
      fstart_nxt = '0;
      match_nxt  = 1'b0;
      mo_nxt     = '{default: '0};
      ovf_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      phase_r  <= fte_pkg::PH_TAG;
      acc_r    <= '0;
      digit_r  <= 1'b0;
      bad_r    <= 1'b0;
      fstart_r <= '0;
      match_r  <= 1'b0;
      mo_r     <= '{default: '0};
      ovf_r    <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      digit_r  <= digit_nxt;
      bad_r    <= bad_nxt;
      fstart_r <= fstart_nxt;
      match_r  <= match_nxt;
      mo_r     <= mo_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

FILE: rtl/fte_out_reg.sv
// ----------------------------------------------------------------------------
// FIX tag/value extractor result register
// Holds one result transaction and frees the input side when it drains.
// ----------------------------------------------------------------------------
module fte_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  fte_pkg::result_t load_data,
  output logic             can_accept,
  output logic             out_valid,
  input  logic             out_ready,
  output fte_pkg::result_t out_data
);

  logic             valid_r, valid_nxt;
  fte_pkg::result_t data_r;

  assign can_accept = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/fix_tag_value_extractor.sv
// ----------------------------------------------------------------------------
// FIX tag/value extractor: results appear the cycle after their byte transaction.
// Throughput is one byte per cycle unless a held result stalls the input;
// the result register is the only stage. Synchronous active-low reset
// clears message state, the result valid flag and the target tag.
// ----------------------------------------------------------------------------
module fix_tag_value_extractor #(
  parameter int OFFSET_BITS = fte_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,    // [7:0] data_byte
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] value_byte, [8] found, [24:9] field_start, [40:25] value_start,
  // [56:41] value_stop, [72:57] field_stop, [73] too_long, [79:74] zero
  output logic [fte_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,   // [0] value_valid
  output logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [fte_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  logic             accept;
  logic             has_result;
  logic [31:0]      target_tag;
  fte_pkg::result_t scan_res;
  fte_pkg::result_t out_res;

  assign accept = in_tvalid && in_tready;

  fte_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .target_tag  (target_tag)
  );

  fte_scanner #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_tdata),
    .last_byte  (in_tlast),
    .target_tag (target_tag),
    .has_result (has_result),
    .result     (scan_res)
  );

  fte_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept && has_result),
    .load_data  (scan_res),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {6'd0, out_res.too_long, out_res.field_stop, out_res.value_stop,
                      out_res.value_start, out_res.field_start, out_res.found,
                      out_res.value_byte};
  assign out_tuser = out_res.value_valid;
  assign out_tlast = out_res.message_done;

endmodule

FILE: rtl/fte_checker.sv
// ----------------------------------------------------------------------------
// FIX tag/value extractor port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "fix_tag_value_extractor_defines.svh"

module fte_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [fte_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser,
  input logic                           out_tlast
);

  `FTE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
  `FTE_ASSERT_NOW(a_in_stall_only_on_full, !in_tready, out_tvalid && !out_tready)
  `FTE_ASSERT_NOW(a_no_value_byte_zero, out_tvalid && !out_tuser, out_tdata[7:0] == 8'd0)
  `FTE_ASSERT_NOW(a_mid_message_no_report, out_tvalid && !out_tlast,
                  out_tuser && (out_tdata[73:8] == '0))
  `FTE_ASSERT_NOW(a_not_found_no_offsets, out_tvalid && out_tlast && !out_tdata[8],
                  out_tdata[72:9] == '0)

endmodule

bind fix_tag_value_extractor fte_checker u_fte_checker (.*);

FILE: sim/tb_fix_tag_value_extractor.sv
// ----------------------------------------------------------------------------
// FIX tag/value extractor testbench
// Streams FIX messages into the extractor and predicts each value byte and
// each end-of-message report in step with the accepted input transactions.
// Directed messages come first. Random messages follow under several tag
// settings, with random stalls on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_fix_tag_value_extractor;

  localparam int          LIMIT       = 2000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          PHASE_BYTES = 225;
  localparam int unsigned OFF_MAX     = (1 << fte_pkg::OFFSET_BITS_DEF) - 1;

  localparam logic [fte_pkg::CFG_ADDR_W-1:0] ADDR_TARGET_TAG = 3'd0;
  localparam logic [fte_pkg::CFG_ADDR_W-1:0] ADDR_UNUSED     = 3'd4;

  typedef struct packed {
    logic       is_last;
    logic [7:0] data;
  } in_item_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata = 8'h00;
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [fte_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;
  logic                           out_tlast;
  logic                           cfg_psel = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite = 1'b0;
  logic [fte_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]                    cfg_pwdata = '0;
  logic [31:0]                    cfg_prdata;
  logic                           cfg_pready;

  in_item_t         msg_bytes[$];
  fte_pkg::result_t field_reports[$];
  logic [7:0]       frame[$];

  int  errors = 0;
  int  stall_cycles = 0;
  int  hold_req = 0;
  int  hold_taken = 0;
  int  hold_left = 0;
  bit  quiet = 1'b0;
  bit  in_acc = 1'b0;

  logic [31:0]     tag_cfg;
  int unsigned     pos;
  fte_pkg::phase_t phase;
  logic [31:0]     acc;
  bit              digit_seen;
  bit              tag_bad;
  int unsigned     fstart;
  bit              hit;
  int unsigned     off[4];
  bit              ovf;

  fix_tag_value_extractor u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic clear_message();
    pos        = 0;
    phase      = fte_pkg::PH_TAG;
    acc        = '0;
    digit_seen = 1'b0;
    tag_bad    = 1'b0;
    fstart     = 0;
    hit        = 1'b0;
    off        = '{0, 0, 0, 0};
    ovf        = 1'b0;
  endtask

  task automatic open_field(input int unsigned nxt);
    phase      = fte_pkg::PH_TAG;
    acc        = '0;
    digit_seen = 1'b0;
    tag_bad    = 1'b0;
    fstart     = nxt;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic is_last);
    int unsigned      p;
    int unsigned      nxt;
    bit               emit;
    logic [31:0]      d;
    fte_pkg::result_t r;
    p    = pos;
    nxt  = (p >= OFF_MAX) ? OFF_MAX : p + 1;
    emit = 1'b0;
    if (p >= OFF_MAX) ovf = 1'b1;
    case (phase)
      fte_pkg::PH_TAG: begin
        if (b == fte_pkg::SOH_BYTE) begin
          open_field(nxt);
        end else if (b == fte_pkg::EQ_BYTE) begin
          if (digit_seen && !tag_bad && acc != 0 && acc == tag_cfg && !hit) begin
            hit    = 1'b1;
            off[0] = fstart;
            off[1] = nxt;
            phase  = fte_pkg::PH_VALUE;
          end else begin
            phase = fte_pkg::PH_SKIP;
          end
        end else if (b >= fte_pkg::DIGIT_LOW && b <= fte_pkg::DIGIT_HIGH) begin
          d          = {24'h0, b - fte_pkg::DIGIT_LOW};
          digit_seen = 1'b1;
          if (!tag_bad) begin
            if (acc > (32'hFFFF_FFFF - d) / 10) tag_bad = 1'b1;
            else acc = acc * 10 + d;
          end
        end else begin
          tag_bad = 1'b1;
        end
      end
      fte_pkg::PH_SKIP: begin
        if (b == fte_pkg::SOH_BYTE) open_field(nxt);
      end
      fte_pkg::PH_VALUE: begin
        if (b == fte_pkg::SOH_BYTE) begin
          off[2] = p;
          off[3] = nxt;
          phase  = fte_pkg::PH_DONE;
        end else begin
          emit = 1'b1;
        end
      end
      default: ;
    endcase
    pos = nxt;
    if (emit || is_last) begin
      r = '0;
      if (emit) begin
        r.value_byte  = b;
        r.value_valid = 1'b1;
      end
      if (is_last) begin
        r.message_done = 1'b1;
        if (hit) begin
          if (phase == fte_pkg::PH_VALUE) begin
            off[2] = nxt;
            off[3] = nxt;
          end
          r.found       = 1'b1;
          r.field_start = off[0][fte_pkg::OUT_OFF_W-1:0];
          r.value_start = off[1][fte_pkg::OUT_OFF_W-1:0];
          r.value_stop  = off[2][fte_pkg::OUT_OFF_W-1:0];
          r.field_stop  = off[3][fte_pkg::OUT_OFF_W-1:0];
        end
        r.too_long = ovf;
        clear_message();
      end
      field_reports.insert(field_reports.size(), r);
    end
  endtask

  task automatic cmp(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      errors++;
    end
  endtask

  task automatic check_report();
    fte_pkg::result_t want;
    fte_pkg::result_t got;
    got              = '0;
    got.value_byte   = out_tdata[7:0];
    got.found        = out_tdata[8];
    got.field_start  = out_tdata[24:9];
    got.value_start  = out_tdata[40:25];
    got.value_stop   = out_tdata[56:41];
    got.field_stop   = out_tdata[72:57];
    got.too_long     = out_tdata[73];
    got.value_valid  = out_tuser;
    got.message_done = out_tlast;
    if (field_reports.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual tdata %h tuser %b tlast %b",
               $time, out_tdata, out_tuser, out_tlast);
      errors++;
    end else begin
      want = field_reports.pop_front();
      cmp("value_byte", want.value_byte, got.value_byte);
      cmp("value_valid", want.value_valid, got.value_valid);
      cmp("message_done", want.message_done, got.message_done);
      cmp("found", want.found, got.found);
      cmp("field_start", want.field_start, got.field_start);
      cmp("value_start", want.value_start, got.value_start);
      cmp("value_stop", want.value_stop, got.value_stop);
      cmp("field_stop", want.field_stop, got.field_stop);
      cmp("too_long", want.too_long, got.too_long);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_acc       <= 1'b0;
      stall_cycles <= 0;
    end else begin
      in_acc <= in_tvalid && in_tready;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (out_tvalid && out_tready) check_report();
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
    end
  end

  always @(negedge clk) begin : drive_bytes
    in_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_acc) begin
      if (msg_bytes.size() != 0 && (quiet || $urandom_range(99) >= 14)) begin
        it = msg_bytes.pop_front();
        in_tdata  <= it.data;
        in_tlast  <= it.is_last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_taken) begin
      hold_taken <= hold_taken + 1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 14);
    end
  end

  initial begin
    wait (rst_n);
    while (stall_cycles < LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  task automatic cfg_access(input bit wr, input logic [fte_pkg::CFG_ADDR_W-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [fte_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] data);
    logic [31:0] rd;
    cfg_access(1'b1, addr, data, rd);
    if (addr == ADDR_TARGET_TAG) tag_cfg = data;
    cfg_access(1'b0, ADDR_TARGET_TAG, '0, rd);
    if (rd !== tag_cfg) begin
      $display("%0t: target tag read mismatch, expected %0h actual %0h", $time, tag_cfg, rd);
      errors++;
    end
  endtask

  task automatic wait_idle();
    while (msg_bytes.size() != 0 || in_tvalid || field_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    frame.insert(frame.size(), b);
  endtask

  task automatic put_dec(input longint unsigned v, input int zeros);
    logic [7:0]      digs[$];
    longint unsigned t;
    repeat (zeros) add_byte(fte_pkg::DIGIT_LOW);
    t = v;
    do begin
      digs.push_front(fte_pkg::DIGIT_LOW + 8'(t % 10));
      t = t / 10;
    end while (t != 0);
    foreach (digs[i]) add_byte(digs[i]);
  endtask

  task automatic flush_frame(inout int count);
    in_item_t it;
    count += frame.size();
    foreach (frame[i]) begin
      it.is_last = (i == frame.size() - 1);
      it.data    = frame[i];
      msg_bytes.insert(msg_bytes.size(), it);
    end
    frame.delete();
  endtask

  function automatic logic [7:0] value_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == fte_pkg::SOH_BYTE);
    return b;
  endfunction

  task automatic build_frame(inout int count);
    int nf;
    int kind;
    int shape;
    bit with_value;
    shape = $urandom_range(99);
    if (shape < 10) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
    end else if (shape < 20) begin
      put_dec($urandom_range(0, 99), $urandom_range(0, 1));
      if ($urandom_range(1)) put_dec(tag_cfg, 0);
    end else begin
      nf = $urandom_range(1, 6);
      for (int f = 0; f < nf; f++) begin
        kind       = $urandom_range(99);
        with_value = 1'b1;
        if (kind < 45) begin
          put_dec(tag_cfg, $urandom_range(0, 2));
        end else if (kind < 60) begin
          put_dec($urandom_range(1, 200), 0);
        end else if (kind < 66) begin
          put_dec(0, $urandom_range(0, 2));
        end else if (kind < 72) begin
          put_dec(64'd4294967296 + $urandom_range(0, 9), 0);
        end else if (kind < 78) begin
        end else if (kind < 86) begin
          put_dec($urandom_range(0, 9), 0);
          add_byte(8'($urandom_range(8'h41, 8'h7A)));
          put_dec($urandom_range(0, 9), 0);
        end else if (kind < 92) begin
          put_dec($urandom_range(1, 99), 0);
          with_value = 1'b0;
        end else begin
          put_dec(32'hFFFF_FFFF, $urandom_range(0, 1));
        end
        if (with_value) begin
          add_byte(fte_pkg::EQ_BYTE);
          repeat ($urandom_range(0, 5)) add_byte(value_char());
        end
        if (f != nf - 1 || $urandom_range(1)) add_byte(fte_pkg::SOH_BYTE);
      end
    end
    flush_frame(count);
  endtask

  initial begin : main_seq
    int          count;
    logic [31:0] tags[7];
    clear_message();
    tag_cfg = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    count = 0;

    write_reg(ADDR_TARGET_TAG, 32'd35);
    add_byte("8"); add_byte(fte_pkg::EQ_BYTE); add_byte("F");
    add_byte(fte_pkg::SOH_BYTE);
    add_byte("0"); add_byte("3"); add_byte("5"); add_byte(fte_pkg::EQ_BYTE);
    add_byte(8'hFF); add_byte(8'h00); add_byte(8'h80);
    add_byte(fte_pkg::SOH_BYTE);
    add_byte("3"); add_byte("5"); add_byte(fte_pkg::EQ_BYTE); add_byte("Z");
    flush_frame(count);
    add_byte(fte_pkg::EQ_BYTE); add_byte("Q"); add_byte(fte_pkg::SOH_BYTE);
    add_byte("5"); add_byte("x"); add_byte(fte_pkg::SOH_BYTE);
    add_byte("3"); add_byte("5"); add_byte(fte_pkg::EQ_BYTE);
    flush_frame(count);
    wait_idle();

    tags = '{32'd35, 32'd1, 32'hFFFF_FFFF, 32'd0, $urandom_range(1, 200), 32'd9999, $urandom};
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(ADDR_TARGET_TAG, tags[ph]);
      if (ph == 5) write_reg(ADDR_UNUSED, $urandom);
      quiet = (ph == 2);
      if (ph == 1 || ph == 4) hold_req++;
      count = 0;
      while (count < PHASE_BYTES) build_frame(count);
      wait_idle();
      quiet = 1'b0;
    end

    repeat (8) @(negedge clk);
    if (field_reports.size() != 0) begin
      $display("%0t: %0d results never arrived, expected %h", $time,
               field_reports.size(), field_reports[0]);
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
